// ===== rtl/core/arc_pkg.sv =====
// Shared types and constants for the ARP responder with address cache.
package arc_pkg;

	localparam logic [15:0] HW_ETHERNET    = 16'h0001;
	localparam logic [15:0] PROTO_IPV4     = 16'h0800;
	localparam logic [7:0]  HW_ADDR_LEN    = 8'd6;
	localparam logic [7:0]  PROTO_ADDR_LEN = 8'd4;
	localparam logic [15:0] OPC_REQUEST    = 16'd1;
	localparam logic [15:0] OPC_REPLY      = 16'd2;

	localparam logic [47:0] MAC_ZERO      = 48'h0000_0000_0000;
	localparam logic [47:0] MAC_BROADCAST = 48'hFFFF_FFFF_FFFF;

	localparam logic [2:0] KIND_DROPPED     = 3'd0;
	localparam logic [2:0] KIND_LEARNED     = 3'd1;
	localparam logic [2:0] KIND_LEARN_REPLY = 3'd2;
	localparam logic [2:0] KIND_UNKNOWN_OP  = 3'd3;
	localparam logic [2:0] KIND_HIT         = 3'd4;
	localparam logic [2:0] KIND_MISS_REQ    = 3'd5;

	localparam logic [1:0] FOP_NONE    = 2'd0;
	localparam logic [1:0] FOP_REQUEST = 2'd1;
	localparam logic [1:0] FOP_REPLY   = 2'd2;

	localparam logic CFG_OWN_MAC = 1'b0;
	localparam logic CFG_OWN_IP  = 1'b1;

	localparam logic OP_PACKET = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	typedef struct packed {
		logic        start;
		logic        insert;
		logic [31:0] key;
		logic [47:0] mac;
	} arc_req_t;

	typedef struct packed {
		logic        done;
		logic        hit;
		logic [47:0] mac;
	} arc_rsp_t;

endpackage

// ===== rtl/core/arc_cache.sv =====
// Address cache: serial search over the entries, then an optional insert.
module arc_cache
	import arc_pkg::*;
#(
	parameter int ENTRIES = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  arc_req_t req,
	output arc_rsp_t rsp
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

	typedef enum logic [1:0] {C_IDLE, C_SCAN, C_WRITE} state_t;

	state_t              state_q;
	logic [IW-1:0]       idx_q;
	logic                issue_q;
	logic                cmp_act_s1;
	logic                cmp_vld_s1;
	logic [IW-1:0]       cmp_idx_s1;
	logic [31:0]         rd_ip_s1;
	logic [47:0]         rd_mac_s1;
	logic                hit_q;
	logic [IW-1:0]       hit_idx_q;
	logic [47:0]         hit_mac_q;
	logic                free_q;
	logic [IW-1:0]       free_idx_q;
	logic [IW-1:0]       repl_q;
	logic [ENTRIES-1:0]  valid_q;
	logic                ins_q;
	logic [31:0]         key_q;
	logic [47:0]         mac_q;
	logic                done_q;

	logic [31:0]         ip_mem  [ENTRIES];
	logic [47:0]         mac_mem [ENTRIES];

	logic                wr_en;
	logic [IW-1:0]       wr_slot;

	assign wr_en   = (state_q == C_WRITE);
	assign wr_slot = hit_q ? hit_idx_q : (free_q ? free_idx_q : repl_q);

	assign rsp.done = done_q;
	assign rsp.hit  = hit_q;
	assign rsp.mac  = hit_mac_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ip_mem[wr_slot]  <= key_q;
			mac_mem[wr_slot] <= mac_q;
		end
		rd_ip_s1  <= ip_mem[idx_q];
		rd_mac_s1 <= mac_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= C_IDLE;
			idx_q      <= '0;
			issue_q    <= 1'b0;
			cmp_act_s1 <= 1'b0;
			cmp_vld_s1 <= 1'b0;
			cmp_idx_s1 <= '0;
			hit_q      <= 1'b0;
			hit_idx_q  <= '0;
			hit_mac_q  <= '0;
			free_q     <= 1'b0;
			free_idx_q <= '0;
			repl_q     <= '0;
			valid_q    <= '0;
			ins_q      <= 1'b0;
			key_q      <= '0;
			mac_q      <= '0;
			done_q     <= 1'b0;
		end else begin
			unique case (state_q)
				C_IDLE: begin
					done_q     <= 1'b0;
					cmp_act_s1 <= 1'b0;
					if (req.start) begin
						key_q   <= req.key;
						mac_q   <= req.mac;
						ins_q   <= req.insert;
						idx_q   <= '0;
						issue_q <= 1'b1;
						hit_q   <= 1'b0;
						free_q  <= 1'b0;
						state_q <= C_SCAN;
					end
				end
				C_SCAN: begin
					cmp_act_s1 <= issue_q;
					cmp_idx_s1 <= idx_q;
					cmp_vld_s1 <= valid_q[idx_q];
					if (issue_q) begin
						if (idx_q == LAST) begin
							issue_q <= 1'b0;
						end else begin
							idx_q <= idx_q + IW'(1);
						end
					end
					if (cmp_act_s1) begin
						if (cmp_vld_s1 && rd_ip_s1 == key_q && !hit_q) begin
							hit_q     <= 1'b1;
							hit_idx_q <= cmp_idx_s1;
							hit_mac_q <= rd_mac_s1;
						end
						if (!cmp_vld_s1 && !free_q) begin
							free_q     <= 1'b1;
							free_idx_q <= cmp_idx_s1;
						end
						if (cmp_idx_s1 == LAST) begin
							if (ins_q) begin
								state_q <= C_WRITE;
							end else begin
								done_q  <= 1'b1;
								state_q <= C_IDLE;
							end
						end
					end
				end
				C_WRITE: begin
					valid_q[wr_slot] <= 1'b1;
					if (!hit_q && !free_q) begin
						repl_q <= (repl_q == LAST) ? '0 : repl_q + IW'(1);
					end
					done_q  <= 1'b1;
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/arp_responder_with_cache.sv =====
// Top level of the ARP responder: packet filter, result forming and cache control.
// A dropped packet or one with an unknown opcode skips the cache and goes from acceptance
// straight to the output state. A lookup or a learned packet gives its result once the cache
// search, which reads one stored entry per cycle, has passed every entry; a learned packet
// also waits for the insert. One item at a time: in_ready is high only in the idle state.
// The asynchronous reset clears the registers, all cache valid bits and the replace pointer.
module arp_responder_with_cache
	import arc_pkg::*;
#(
	parameter int CACHE_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [47:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [47:0] target_mac,
	input  logic [15:0] hw_kind,
	input  logic [15:0] proto_kind,
	input  logic [7:0]  hw_len,
	input  logic [7:0]  proto_len,
	input  logic [15:0] arp_opcode,
	input  logic [47:0] sender_mac,
	input  logic [31:0] sender_ip,
	input  logic [31:0] query_ip,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  result_kind,
	output logic [1:0]  frame_opcode,
	output logic [47:0] frame_dest_mac,
	output logic [31:0] frame_target_ip,
	output logic [47:0] found_mac,
	output logic [31:0] retry_ip
);

	typedef enum logic [1:0] {S_IDLE, S_WAIT, S_OUT} state_t;

	state_t      state_q;
	logic [47:0] own_mac_q;
	logic [31:0] own_ip_q;
	logic        lookup_q;
	logic        is_req_q;
	logic [31:0] key_q;
	logic [47:0] smac_q;
	logic        start_q;
	logic        insert_q;

	logic [2:0]  pend_kind_q;
	logic [1:0]  pend_fop_q;
	logic [47:0] pend_dest_q;
	logic [31:0] pend_tip_q;
	logic [47:0] pend_found_q;
	logic [31:0] pend_retry_q;

	logic        out_valid_q;
	logic [2:0]  out_kind_q;
	logic [1:0]  out_fop_q;
	logic [47:0] out_dest_q;
	logic [31:0] out_tip_q;
	logic [47:0] out_found_q;
	logic [31:0] out_retry_q;

	logic        accept;
	logic        pass;
	logic        known_op;
	logic        out_free;
	arc_req_t    creq;
	arc_rsp_t    crsp;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	assign pass = (target_mac == MAC_ZERO || target_mac == own_mac_q) &&
		hw_kind == HW_ETHERNET && proto_kind == PROTO_IPV4 &&
		hw_len == HW_ADDR_LEN && proto_len == PROTO_ADDR_LEN;
	assign known_op = (arp_opcode == OPC_REQUEST) || (arp_opcode == OPC_REPLY);

	assign creq.start  = start_q;
	assign creq.insert = insert_q;
	assign creq.key    = key_q;
	assign creq.mac    = smac_q;

	assign out_valid       = out_valid_q;
	assign result_kind     = out_kind_q;
	assign frame_opcode    = out_fop_q;
	assign frame_dest_mac  = out_dest_q;
	assign frame_target_ip = out_tip_q;
	assign found_mac       = out_found_q;
	assign retry_ip        = out_retry_q;

	arc_cache #(
		.ENTRIES(CACHE_ENTRIES)
	) u_cache (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (creq),
		.rsp    (crsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_mac_q <= '0;
			own_ip_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_OWN_MAC: own_mac_q <= cfg_data;
				CFG_OWN_IP:  own_ip_q  <= cfg_data[31:0];
				default:     own_ip_q  <= own_ip_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			lookup_q     <= 1'b0;
			is_req_q     <= 1'b0;
			key_q        <= '0;
			smac_q       <= '0;
			start_q      <= 1'b0;
			insert_q     <= 1'b0;
			pend_kind_q  <= KIND_DROPPED;
			pend_fop_q   <= FOP_NONE;
			pend_dest_q  <= '0;
			pend_tip_q   <= '0;
			pend_found_q <= '0;
			pend_retry_q <= '0;
			out_valid_q  <= 1'b0;
			out_kind_q   <= KIND_DROPPED;
			out_fop_q    <= FOP_NONE;
			out_dest_q   <= '0;
			out_tip_q    <= '0;
			out_found_q  <= '0;
			out_retry_q  <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						pend_fop_q   <= FOP_NONE;
						pend_dest_q  <= '0;
						pend_tip_q   <= '0;
						pend_found_q <= '0;
						pend_retry_q <= '0;
						lookup_q     <= (op == OP_LOOKUP);
						is_req_q     <= (arp_opcode == OPC_REQUEST);
						key_q        <= (op == OP_LOOKUP) ? query_ip : sender_ip;
						smac_q       <= sender_mac;
						insert_q     <= (op == OP_PACKET);
						if (op == OP_LOOKUP || (pass && known_op)) begin
							start_q <= 1'b1;
							state_q <= S_WAIT;
						end else begin
							pend_kind_q <= pass ? KIND_UNKNOWN_OP : KIND_DROPPED;
							state_q     <= S_OUT;
						end
					end
				end
				S_WAIT: begin
					start_q <= 1'b0;
					if (crsp.done) begin
						if (lookup_q) begin
							if (crsp.hit) begin
								pend_kind_q  <= KIND_HIT;
								pend_found_q <= crsp.mac;
							end else begin
								pend_kind_q <= KIND_MISS_REQ;
								pend_fop_q  <= FOP_REQUEST;
								pend_dest_q <= MAC_BROADCAST;
								pend_tip_q  <= key_q;
							end
						end else begin
							pend_retry_q <= key_q;
							if (is_req_q) begin
								pend_kind_q <= KIND_LEARN_REPLY;
								pend_fop_q  <= FOP_REPLY;
								pend_dest_q <= smac_q;
								pend_tip_q  <= key_q;
							end else begin
								pend_kind_q <= KIND_LEARNED;
							end
						end
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= pend_kind_q;
						out_fop_q   <= pend_fop_q;
						out_dest_q  <= pend_dest_q;
						out_tip_q   <= pend_tip_q;
						out_found_q <= pend_found_q;
						out_retry_q <= pend_retry_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/arc_checker.sv =====
// Port-level checks for the ARP responder, bound to the top level.
module arc_checker
	import arc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  result_kind,
	input logic [1:0]  frame_opcode,
	input logic [47:0] frame_dest_mac,
	input logic [31:0] frame_target_ip,
	input logic [47:0] found_mac,
	input logic [31:0] retry_ip
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_kind) &&
		$stable(frame_dest_mac) && $stable(retry_ip))
		else $error("result changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("new item taken while one is in work");

	a_hit_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_HIT |->
		frame_opcode == FOP_NONE && frame_dest_mac == '0 && retry_ip == '0)
		else $error("hit result carries a frame or retry address");

	a_miss_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_MISS_REQ |->
		frame_opcode == FOP_REQUEST && frame_dest_mac == MAC_BROADCAST && found_mac == '0)
		else $error("miss result without broadcast request");

	a_drop_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind == KIND_DROPPED || result_kind == KIND_UNKNOWN_OP) |->
		frame_opcode == FOP_NONE && frame_target_ip == '0 && retry_ip == '0)
		else $error("dropped packet produced a frame or retry address");

endmodule

bind arp_responder_with_cache arc_checker u_arc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.result_kind     (result_kind),
	.frame_opcode    (frame_opcode),
	.frame_dest_mac  (frame_dest_mac),
	.frame_target_ip (frame_target_ip),
	.found_mac       (found_mac),
	.retry_ip        (retry_ip)
);
